/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Short forms for the concurrent checks used in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// When the antecedent holds, the consequent must hold in the same cycle.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// When the antecedent holds, the consequent must hold in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// The expression must never hold.
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error(msg);

`endif

/* rtl/core/oal_pkg.sv */
// ----------------------------------------------------------------------------
// oal_pkg
// Shared types, codes and field widths of the ordered array list engine.
// ----------------------------------------------------------------------------
package oal_pkg;

  // Default configuration.
  localparam int DEF_CAPACITY   = 16;
  localparam int DEF_DATA_WIDTH = 32;

  // Fixed widths of the request and result fields.
  localparam int REQ_W   = 3;
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int ST_W    = 3;
  localparam int FOUND_W = 4;
  localparam int CNTO_W  = 5;

  // Request kinds.
  localparam logic [REQ_W-1:0] REQ_APPEND = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INSERT = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE = 3'd2;
  localparam logic [REQ_W-1:0] REQ_SEARCH = 3'd3;
  localparam logic [REQ_W-1:0] REQ_UPDATE = 3'd4;
  localparam logic [REQ_W-1:0] REQ_CLEAR  = 3'd5;

  // Result status codes.
  localparam logic [ST_W-1:0] ST_OK        = 3'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd1;
  localparam logic [ST_W-1:0] ST_BAD_POS   = 3'd2;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [ST_W-1:0] ST_EMPTY     = 3'd4;

  // Start points of the slot cursor.
  localparam logic [1:0] CUR_ZERO = 2'd0;
  localparam logic [1:0] CUR_LAST = 2'd1;
  localparam logic [1:0] CUR_NEXT = 2'd2;

  // Length counter operations.
  localparam logic [1:0] CNT_HOLD = 2'd0;
  localparam logic [1:0] CNT_INC  = 2'd1;
  localparam logic [1:0] CNT_DEC  = 2'd2;
  localparam logic [1:0] CNT_CLR  = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            load_req;    // capture the request fields
    logic            cur_load;    // load the cursor from cur_sel
    logic [1:0]      cur_sel;
    logic            rd_en;       // read the slot under the cursor and step it
    logic            cur_up;      // step direction of the cursor
    logic            mv_en;       // write the last read entry one slot over
    logic            mv_up;       // move direction of that entry
    logic            put_en;      // write the request value
    logic            put_at_pos;  // at the request position, else at the end
    logic [1:0]      cnt_op;
    logic            fin;         // capture the result
    logic [ST_W-1:0] fin_status;
    logic            fin_found;   // report the last read slot as found
  } oal_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic             pos_gt_cnt;
    logic             pos_ge_cnt;
    logic             pos_eq_cnt;
    logic             pos_is_last;
    logic             cnt_zero;
    logic             cnt_full;
    logic             cur_at_pos;
    logic             cur_at_last;
    logic             match;
  } oal_stat_t;

endpackage

/* rtl/core/oal_dp.sv */
// ----------------------------------------------------------------------------
// oal_dp
// Datapath: request registers, slot memory, length counter, cursor,
// comparator and result registers.
// ----------------------------------------------------------------------------
module oal_dp import oal_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  oal_cmd_t           cmd,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [POS_W-1:0]   position,
  input  logic [VAL_W-1:0]   item_value,
  output oal_stat_t          stat,
  output logic [ST_W-1:0]    status,
  output logic [FOUND_W-1:0] found_position,
  output logic [CNTO_W-1:0]  count_now
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int PW = (CW > POS_W) ? CW : POS_W;

  logic [REQ_W-1:0]      kind;
  logic [POS_W-1:0]      pos;
  logic [DATA_WIDTH-1:0] val;
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;
  logic [AW-1:0]         cursor;
  logic [AW-1:0]         rd_addr;
  logic [DATA_WIDTH-1:0] rdata;
  logic [DATA_WIDTH-1:0] mem [CAPACITY];

  logic                  we;
  logic [AW-1:0]         waddr;
  logic [DATA_WIDTH-1:0] wdata;
  logic [PW-1:0]         pos_ext;
  logic [PW-1:0]         cnt_ext;

  assign pos_ext = PW'(pos);
  assign cnt_ext = PW'(count);

  // Capture the request fields when a transaction is accepted.
  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      kind <= req_type;
      pos  <= position;
      val  <= DATA_WIDTH'(item_value);
    end
  end

  // Length counter.
  always_comb begin
    unique case (cmd.cnt_op)
      CNT_HOLD: count_next = count;
      CNT_INC:  count_next = CW'(count + 1'b1);
      CNT_DEC:  count_next = CW'(count - 1'b1);
      CNT_CLR:  count_next = '0;
      default:  count_next = count;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      count <= count_next;
    end
  end

  // Slot cursor: loaded at the start of a walk, stepped on each read.
  always_ff @(posedge clk) begin
    if (cmd.cur_load) begin
      unique case (cmd.cur_sel)
        CUR_ZERO: cursor <= '0;
        CUR_LAST: cursor <= AW'(count - 1'b1);
        CUR_NEXT: cursor <= AW'(pos_ext + 1'b1);
        default:  cursor <= '0;
      endcase
    end else if (cmd.rd_en) begin
      cursor <= cmd.cur_up ? AW'(cursor + 1'b1) : AW'(cursor - 1'b1);
    end
  end

  // Write port: either a moved entry or the request value.
  assign we = cmd.mv_en | cmd.put_en;

  always_comb begin
    if (cmd.mv_en) begin
      waddr = cmd.mv_up ? AW'(rd_addr + 1'b1) : AW'(rd_addr - 1'b1);
      wdata = rdata;
    end else begin
      waddr = cmd.put_at_pos ? AW'(pos) : AW'(count);
      wdata = val;
    end
  end

  // Slot memory with one write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rdata   <= mem[cursor];
      rd_addr <= cursor;
    end
  end

  // Status towards the controller.
  assign stat.kind        = kind;
  assign stat.pos_gt_cnt  = pos_ext > cnt_ext;
  assign stat.pos_ge_cnt  = pos_ext >= cnt_ext;
  assign stat.pos_eq_cnt  = pos_ext == cnt_ext;
  assign stat.pos_is_last = PW'(pos_ext + 1'b1) == cnt_ext;
  assign stat.cnt_zero    = count == '0;
  assign stat.cnt_full    = count == CW'(CAPACITY);
  assign stat.cur_at_pos  = PW'(cursor) == pos_ext;
  assign stat.cur_at_last = CW'(cursor) == CW'(count - 1'b1);
  assign stat.match       = rdata == val;

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      status         <= cmd.fin_status;
      found_position <= cmd.fin_found ? FOUND_W'(rd_addr) : '0;
      count_now      <= CNTO_W'(count_next);
    end
  end

endmodule

/* rtl/core/oal_ctrl.sv */
// ----------------------------------------------------------------------------
// oal_ctrl
// Controller: decides each request and sequences the slot walks of insert,
// remove and search.
// ----------------------------------------------------------------------------
module oal_ctrl import oal_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  oal_stat_t stat,
  output oal_cmd_t  cmd,
  output logic      busy,
  output logic      done
);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_DECIDE  = 4'd1;
  localparam logic [3:0] S_WALK_UP = 4'd2;
  localparam logic [3:0] S_TAIL_UP = 4'd3;
  localparam logic [3:0] S_PUT     = 4'd4;
  localparam logic [3:0] S_WALK_DN = 4'd5;
  localparam logic [3:0] S_TAIL_DN = 4'd6;
  localparam logic [3:0] S_WALK_SR = 4'd7;
  localparam logic [3:0] S_TAIL_SR = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic       rd_pend;

  assign busy = state != S_IDLE;

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load_req = 1'b1;
          state_next   = S_DECIDE;
        end
      end

      S_DECIDE: begin
        state_next = S_IDLE;
        unique case (stat.kind)
          REQ_APPEND: begin
            cmd.fin = 1'b1;
            if (stat.cnt_full) begin
              cmd.fin_status = ST_FULL;
            end else begin
              cmd.put_en     = 1'b1;
              cmd.cnt_op     = CNT_INC;
              cmd.fin_status = ST_OK;
            end
          end
          REQ_INSERT: begin
            priority if (stat.pos_gt_cnt) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_BAD_POS;
            end else if (stat.cnt_full) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_FULL;
            end else if (stat.pos_eq_cnt) begin
              cmd.put_en     = 1'b1;
              cmd.put_at_pos = 1'b1;
              cmd.cnt_op     = CNT_INC;
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_OK;
            end else begin
              cmd.cur_load = 1'b1;
              cmd.cur_sel  = CUR_LAST;
              state_next   = S_WALK_UP;
            end
          end
          REQ_REMOVE: begin
            priority if (stat.pos_ge_cnt) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_BAD_POS;
            end else if (stat.pos_is_last) begin
              cmd.cnt_op     = CNT_DEC;
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_OK;
            end else begin
              cmd.cur_load = 1'b1;
              cmd.cur_sel  = CUR_NEXT;
              state_next   = S_WALK_DN;
            end
          end
          REQ_SEARCH: begin
            if (stat.cnt_zero) begin
              cmd.fin        = 1'b1;
              cmd.fin_status = ST_EMPTY;
            end else begin
              cmd.cur_load = 1'b1;
              cmd.cur_sel  = CUR_ZERO;
              state_next   = S_WALK_SR;
            end
          end
          REQ_UPDATE: begin
            cmd.fin = 1'b1;
            priority if (stat.cnt_zero) begin
              cmd.fin_status = ST_EMPTY;
            end else if (stat.pos_ge_cnt) begin
              cmd.fin_status = ST_BAD_POS;
            end else begin
              cmd.put_en     = 1'b1;
              cmd.put_at_pos = 1'b1;
              cmd.fin_status = ST_OK;
            end
          end
          REQ_CLEAR: begin
            cmd.cnt_op     = CNT_CLR;
            cmd.fin        = 1'b1;
            cmd.fin_status = ST_OK;
          end
          default: begin
            cmd.fin        = 1'b1;
            cmd.fin_status = ST_OK;
          end
        endcase
      end

      // Insert: read downwards from the last entry, each entry moving up one.
      S_WALK_UP: begin
        cmd.rd_en = 1'b1;
        cmd.mv_en = rd_pend;
        cmd.mv_up = 1'b1;
        if (stat.cur_at_pos) begin
          state_next = S_TAIL_UP;
        end
      end

      S_TAIL_UP: begin
        cmd.mv_en  = 1'b1;
        cmd.mv_up  = 1'b1;
        state_next = S_PUT;
      end

      S_PUT: begin
        cmd.put_en     = 1'b1;
        cmd.put_at_pos = 1'b1;
        cmd.cnt_op     = CNT_INC;
        cmd.fin        = 1'b1;
        cmd.fin_status = ST_OK;
        state_next     = S_IDLE;
      end

      // Remove: read upwards from the entry after the gap, each moving down.
      S_WALK_DN: begin
        cmd.rd_en  = 1'b1;
        cmd.cur_up = 1'b1;
        cmd.mv_en  = rd_pend;
        if (stat.cur_at_last) begin
          state_next = S_TAIL_DN;
        end
      end

      S_TAIL_DN: begin
        cmd.mv_en      = 1'b1;
        cmd.cnt_op     = CNT_DEC;
        cmd.fin        = 1'b1;
        cmd.fin_status = ST_OK;
        state_next     = S_IDLE;
      end

      // Search: compare each read entry, stop at the first match.
      S_WALK_SR: begin
        if (rd_pend && stat.match) begin
          cmd.fin        = 1'b1;
          cmd.fin_status = ST_OK;
          cmd.fin_found  = 1'b1;
          state_next     = S_IDLE;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.cur_up = 1'b1;
          if (stat.cur_at_last) begin
            state_next = S_TAIL_SR;
          end
        end
      end

      S_TAIL_SR: begin
        cmd.fin        = 1'b1;
        cmd.fin_status = stat.match ? ST_OK : ST_NOT_FOUND;
        cmd.fin_found  = stat.match;
        state_next     = S_IDLE;
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, read tracking and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= cmd.rd_en;
      done    <= cmd.fin;
    end
  end

endmodule

/* rtl/core/ordered_array_list_engine.sv */
// ----------------------------------------------------------------------------
// ordered_array_list_engine
// Bounded ordered list of values with append, insert, remove, search,
// update and clear requests, one result per request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on status, found_position and count_now for exactly one cycle with done
// high, and must be captured then, as the block cannot be stalled. Append,
// update, clear, insert at the end, every rejected request and removal of
// the last entry finish in the decide state. Insert at position p walks the
// slot memory from the last entry down to p, remove at p walks it from
// p + 1 up to the last entry, and search walks it from slot 0 up to the
// first match, all through its single read port one slot per cycle. A new
// request can be accepted in the cycle in which done is high.
`include "assert_macros.svh"

module ordered_array_list_engine import oal_pkg::*; #(
  parameter int CAPACITY   = DEF_CAPACITY,
  parameter int DATA_WIDTH = DEF_DATA_WIDTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [REQ_W-1:0]   req_type,
  input  logic [POS_W-1:0]   position,
  input  logic [VAL_W-1:0]   item_value,
  output logic               done,
  output logic [ST_W-1:0]    status,
  output logic [FOUND_W-1:0] found_position,
  output logic [CNTO_W-1:0]  count_now
);

  // Length reported alongside a full status.
  localparam logic [CNTO_W-1:0] FULL_LEN = CNTO_W'(CAPACITY);

  oal_cmd_t  cmd;
  oal_stat_t stat;

  // Controller.
  oal_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Datapath.
  oal_dp #(
    .CAPACITY   (CAPACITY),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .req_type       (req_type),
    .position       (position),
    .item_value     (item_value),
    .stat           (stat),
    .status         (status),
    .found_position (found_position),
    .count_now      (count_now)
  );

  // A result is only presented once the transaction has finished.
  `ASSERT_IMPL(a_done_idle, clk, rst, done, !busy, "result strobe while busy")

  // An accepted transaction keeps the block busy in the following cycle.
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy, "accept without busy")

  // The slot memory has one write port.
  `ASSERT_NEVER(a_one_write, clk, rst, cmd.mv_en && cmd.put_en, "two slot writes")

  // A full status always reports a length of CAPACITY.
  `ASSERT_IMPL(a_full_len, clk, rst, done && status == ST_FULL, count_now == FULL_LEN, "bad length")

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ordered array list engine.
// ----------------------------------------------------------------------------
// Requests are driven on the falling edge and each one is held until the
// engine takes it. A shadow copy of the list, kept in the bench, works out
// each expected result when its request is taken. Every strobed result is
// compared with the oldest outstanding expectation. A short table of
// directed requests covers the empty and out-of-range cases. Random
// traffic follows, with fills to capacity, duplicate values and random gaps
// on the request side.
// ----------------------------------------------------------------------------
module tb import oal_pkg::*; ();

  localparam int LIST_DEPTH   = DEF_CAPACITY;
  localparam int RANDOM_ITEMS = 650;
  localparam int DIR_ROWS     = 25;
  localparam int SETTLE_CYCLES = 25;

  // Request codes that the engine ignores.
  localparam logic [REQ_W-1:0] REQ_SPARE_A = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_B = 3'd7;

  typedef struct packed {
    logic [REQ_W-1:0] kind;
    logic [POS_W-1:0] pos;
    logic [VAL_W-1:0] val;
  } list_req_t;

  typedef struct packed {
    logic [ST_W-1:0]    st;
    logic [FOUND_W-1:0] fpos;
    logic [CNTO_W-1:0]  cnt;
  } list_result_t;

  // One row of the directed table: a request and, where marked, the result
  // that it must give.
  typedef struct packed {
    logic [REQ_W-1:0]   kind;
    logic [POS_W-1:0]   pos;
    logic [VAL_W-1:0]   val;
    logic               fixed_exp;
    logic [ST_W-1:0]    st;
    logic [FOUND_W-1:0] fpos;
    logic [CNTO_W-1:0]  cnt;
  } dir_row_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic [REQ_W-1:0]   req_type;
  logic [POS_W-1:0]   position;
  logic [VAL_W-1:0]   item_value;
  logic               done;
  logic [ST_W-1:0]    status;
  logic [FOUND_W-1:0] found_position;
  logic [CNTO_W-1:0]  count_now;

  // Shadow copy of the list contents and length.
  logic [VAL_W-1:0]  shadow_slots [LIST_DEPTH];
  logic [CNTO_W-1:0] shadow_len;

  list_result_t pending_results [$];
  int           err_count;
  int           issued;
  bit           gapless;

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{REQ_SEARCH,  5'd0,  32'h0000_0000, 1'b1, ST_EMPTY,     4'd0, 5'd0},
    '{REQ_UPDATE,  5'd0,  32'h0000_0001, 1'b1, ST_EMPTY,     4'd0, 5'd0},
    '{REQ_REMOVE,  5'd0,  32'h0000_0000, 1'b1, ST_BAD_POS,   4'd0, 5'd0},
    '{REQ_INSERT,  5'd1,  32'h0000_0002, 1'b1, ST_BAD_POS,   4'd0, 5'd0},
    '{REQ_INSERT,  5'd16, 32'h0000_0003, 1'b1, ST_BAD_POS,   4'd0, 5'd0},
    '{REQ_CLEAR,   5'd0,  32'h0000_0000, 1'b1, ST_OK,        4'd0, 5'd0},
    '{REQ_APPEND,  5'd0,  32'h0000_0000, 1'b1, ST_OK,        4'd0, 5'd1},
    '{REQ_APPEND,  5'd16, 32'hFFFF_FFFF, 1'b1, ST_OK,        4'd0, 5'd2},
    '{REQ_INSERT,  5'd0,  32'hA5A5_A5A5, 1'b1, ST_OK,        4'd0, 5'd3},
    '{REQ_INSERT,  5'd3,  32'h5A5A_5A5A, 1'b1, ST_OK,        4'd0, 5'd4},
    '{REQ_INSERT,  5'd1,  32'hFFFF_FFFF, 1'b0, ST_OK,        4'd0, 5'd0},
    '{REQ_SEARCH,  5'd0,  32'hFFFF_FFFF, 1'b0, ST_OK,        4'd0, 5'd0},
    '{REQ_SEARCH,  5'd0,  32'h1234_5678, 1'b1, ST_NOT_FOUND, 4'd0, 5'd5},
    '{REQ_UPDATE,  5'd5,  32'h0000_0004, 1'b1, ST_BAD_POS,   4'd0, 5'd5},
    '{REQ_UPDATE,  5'd16, 32'h0000_0005, 1'b1, ST_BAD_POS,   4'd0, 5'd5},
    '{REQ_REMOVE,  5'd5,  32'h0000_0000, 1'b1, ST_BAD_POS,   4'd0, 5'd5},
    '{REQ_UPDATE,  5'd2,  32'h1234_5678, 1'b0, ST_OK,        4'd0, 5'd0},
    '{REQ_SEARCH,  5'd0,  32'h1234_5678, 1'b0, ST_OK,        4'd0, 5'd0},
    '{REQ_REMOVE,  5'd0,  32'h0000_0000, 1'b0, ST_OK,        4'd0, 5'd0},
    '{REQ_REMOVE,  5'd3,  32'h0000_0000, 1'b0, ST_OK,        4'd0, 5'd0},
    '{REQ_SPARE_A, 5'd9,  32'hDEAD_BEEF, 1'b0, ST_OK,        4'd0, 5'd0},
    '{REQ_SPARE_B, 5'd31, 32'hFFFF_FFFF, 1'b0, ST_OK,        4'd0, 5'd0},
    '{REQ_CLEAR,   5'd7,  32'h0000_0000, 1'b1, ST_OK,        4'd0, 5'd0},
    '{REQ_SEARCH,  5'd0,  32'h0000_0000, 1'b1, ST_EMPTY,     4'd0, 5'd0},
    '{REQ_REMOVE,  5'd0,  32'h0000_0000, 1'b1, ST_BAD_POS,   4'd0, 5'd0}
  };

  ordered_array_list_engine uut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .req_type       (req_type),
    .position       (position),
    .item_value     (item_value),
    .done           (done),
    .status         (status),
    .found_position (found_position),
    .count_now      (count_now)
  );

  // Free-running clock with a 20 ns period.
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Apply one request to the shadow list and return the result it gives.
  function automatic list_result_t apply_request(input list_req_t r);
    list_result_t res;
    int           len;
    int           p;
    int           i;
    res = '{st: ST_OK, fpos: '0, cnt: '0};
    len = int'(shadow_len);
    p   = int'(r.pos);
    case (r.kind)
      REQ_APPEND: begin
        if (len >= LIST_DEPTH) begin
          res.st = ST_FULL;
        end else begin
          shadow_slots[len] = r.val;
          len++;
        end
      end
      REQ_INSERT: begin
        // The range check takes priority over the full check.
        if (p > len) begin
          res.st = ST_BAD_POS;
        end else if (len >= LIST_DEPTH) begin
          res.st = ST_FULL;
        end else begin
          for (i = len; i > p; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[p] = r.val;
          len++;
        end
      end
      REQ_REMOVE: begin
        if (p >= len) begin
          res.st = ST_BAD_POS;
        end else begin
          for (i = p; i + 1 < len; i++) shadow_slots[i] = shadow_slots[i+1];
          len--;
        end
      end
      REQ_SEARCH: begin
        // The first matching slot wins.
        if (len == 0) begin
          res.st = ST_EMPTY;
        end else begin
          res.st = ST_NOT_FOUND;
          for (i = 0; i < len; i++) begin
            if (res.st == ST_NOT_FOUND && shadow_slots[i] == r.val) begin
              res.st   = ST_OK;
              res.fpos = i[FOUND_W-1:0];
            end
          end
        end
      end
      REQ_UPDATE: begin
        if (len == 0) res.st = ST_EMPTY;
        else if (p >= len) res.st = ST_BAD_POS;
        else shadow_slots[p] = r.val;
      end
      REQ_CLEAR: begin
        len = 0;
      end
      default: begin
      end
    endcase
    shadow_len = len[CNTO_W-1:0];
    res.cnt    = shadow_len;
    return res;
  endfunction

  // Values lean towards the extremes and a few small numbers so that
  // duplicates turn up in the list.
  function automatic logic [VAL_W-1:0] pick_value();
    logic [VAL_W-1:0] v;
    case ($urandom_range(0, 9))
      0:       v = '0;
      1:       v = '1;
      2, 3:    v = $urandom_range(0, 7);
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // Mostly a position inside the list, sometimes anywhere in range.
  function automatic logic [POS_W-1:0] pick_position(input bit allow_end);
    int top;
    top = int'(shadow_len) - (allow_end ? 0 : 1);
    if (top < 0 || $urandom_range(0, 99) < 20) begin
      return POS_W'($urandom_range(0, LIST_DEPTH));
    end
    return POS_W'($urandom_range(0, top));
  endfunction

  // Present one request, hold it until the engine takes it, then record
  // the expected result.
  task automatic send_request(input list_req_t r, input bit use_fixed,
                              input list_result_t fixed_res);
    list_result_t res;
    while (!gapless && $urandom_range(0, 99) < 23) begin
      @(negedge clk);
      start <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    start      <= 1'b1;
    req_type   <= r.kind;
    position   <= r.pos;
    item_value <= r.val;
    do @(posedge clk); while (busy);
    res = apply_request(r);
    if (use_fixed) res = fixed_res;
    pending_results.insert(pending_results.size(), res);
    issued++;
  endtask

  task automatic send_plain(input logic [REQ_W-1:0] kind, input logic [POS_W-1:0] pos,
                            input logic [VAL_W-1:0] val);
    send_request('{kind: kind, pos: pos, val: val}, 1'b0, '0);
  endtask

  // Hold off new requests until every outstanding result has come back.
  // The request just taken is withdrawn first so that it is not taken again.
  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Fill the list to capacity, then probe the full and last-slot cases.
  task automatic fill_and_probe();
    while (int'(shadow_len) < LIST_DEPTH)
      send_plain(REQ_APPEND, POS_W'($urandom_range(0, LIST_DEPTH)), $urandom);
    send_plain(REQ_APPEND, 5'd0, pick_value());
    send_plain(REQ_INSERT, POS_W'(LIST_DEPTH), pick_value());
    send_plain(REQ_INSERT, 5'd0, pick_value());
    send_plain(REQ_SEARCH, 5'd0, shadow_slots[LIST_DEPTH-1]);
    send_plain(REQ_UPDATE, POS_W'(LIST_DEPTH - 1), '1);
    send_plain(REQ_SEARCH, 5'd0, '1);
    send_plain(REQ_REMOVE, POS_W'(LIST_DEPTH - 1), '0);
  endtask

  // One random request, weighted so the list often grows to capacity.
  task automatic send_random();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 22) begin
      send_plain(REQ_APPEND, POS_W'($urandom_range(0, LIST_DEPTH)), pick_value());
    end else if (pick < 40) begin
      send_plain(REQ_INSERT, pick_position(1'b1), pick_value());
    end else if (pick < 58) begin
      send_plain(REQ_REMOVE, pick_position(1'b0), pick_value());
    end else if (pick < 75) begin
      if (shadow_len != 0 && $urandom_range(0, 99) < 60)
        send_plain(REQ_SEARCH, pick_position(1'b0),
                   shadow_slots[$urandom_range(0, int'(shadow_len) - 1)]);
      else
        send_plain(REQ_SEARCH, POS_W'($urandom_range(0, LIST_DEPTH)), pick_value());
    end else if (pick < 91) begin
      send_plain(REQ_UPDATE, pick_position(1'b0), pick_value());
    end else if (pick < 94) begin
      send_plain(REQ_CLEAR, POS_W'($urandom_range(0, LIST_DEPTH)), pick_value());
    end else begin
      send_plain($urandom_range(0, 1) ? REQ_SPARE_A : REQ_SPARE_B,
                 POS_W'($urandom_range(0, 31)), $urandom);
    end
  endtask

  // Compare each strobed result with the oldest expectation.
  always @(posedge clk) begin : check_results
    list_result_t want;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("Unexpected result: status=%0d found=%0d count=%0d",
                   status, found_position, count_now);
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st || found_position !== want.fpos ||
            count_now !== want.cnt) begin
          err_count++;
          if (err_count <= 10)
            $display("Mismatch at %0t: exp st=%0d fp=%0d cnt=%0d, got st=%0d fp=%0d cnt=%0d",
                     $realtime, want.st, want.fpos, want.cnt,
                     status, found_position, count_now);
        end
      end
    end
  end

  // Main sequence: reset, directed table, random traffic, drain.
  initial begin : main_flow
    int settle;
    start      = 1'b0;
    req_type   = REQ_APPEND;
    position   = '0;
    item_value = '0;
    rst        = 1'b1;
    shadow_len = '0;
    err_count  = 0;
    issued     = 0;
    gapless    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed requests, with the fixed result used where the row has one.
    foreach (dir_rows[k])
      send_request('{kind: dir_rows[k].kind, pos: dir_rows[k].pos, val: dir_rows[k].val},
                   dir_rows[k].fixed_exp,
                   '{st: dir_rows[k].st, fpos: dir_rows[k].fpos, cnt: dir_rows[k].cnt});
    wait_drained();

    // Random traffic with periodic fills to capacity, a stretch without
    // gaps and a pause until everything has come back.
    issued = 0;
    fill_and_probe();
    while (issued < RANDOM_ITEMS) begin
      gapless = (issued >= 150 && issued < 300);
      if (issued >= 400 && issued < 401) wait_drained();
      if (issued % 120 == 119) fill_and_probe();
      else send_random();
    end
    @(negedge clk);
    start <= 1'b0;

    // Let the last results arrive, then allow a few spare cycles.
    settle = 0;
    while (pending_results.size() != 0 && settle < 1000) begin
      @(posedge clk);
      settle++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0d expected results never arrived", pending_results.size());
      err_count += pending_results.size();
    end

    if (err_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #4_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
